@@ hdl/n7seg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n7seg_pkg
// Types, constants and the glyph table for the seven-segment number formatter.
// ----------------------------------------------------------------------------
package n7seg_pkg;

  localparam int DIGITS_DEFAULT = 4;

  localparam int VALUE_W  = 32;
  localparam int RADIX_W  = 5;
  localparam int FRAC_W   = 3;
  localparam int IN_W     = 40;
  localparam int SEG_W    = 8;
  localparam int OUT_W    = 4 * SEG_W;

  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 48;
  localparam int RND_W     = PROD_W - FRAC_BITS;
  localparam int CMP_W     = 33;
  localparam int CNT_W     = 4;

  localparam logic [RADIX_W-1:0]   RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0]   RADIX_MAX  = 5'd16;
  localparam logic [FRAC_W-1:0]    FRAC_MAX   = 3'd4;
  localparam logic [FRAC_BITS-1:0] ROUND_HALF = 16'h8000;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_SCALE,
    ST_CONV,
    ST_FMT
  } state_t;

  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] g;
    unique case (d)
      4'h0: g = 7'h3F;
      4'h1: g = 7'h06;
      4'h2: g = 7'h5B;
      4'h3: g = 7'h4F;
      4'h4: g = 7'h66;
      4'h5: g = 7'h6D;
      4'h6: g = 7'h7D;
      4'h7: g = 7'h07;
      4'h8: g = 7'h7F;
      4'h9: g = 7'h6F;
      4'hA: g = 7'h77;
      4'hB: g = 7'h7C;
      4'hC: g = 7'h39;
      4'hD: g = 7'h5E;
      4'hE: g = 7'h79;
      4'hF: g = 7'h71;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

@@ hdl/number_to_seven_segment_digits_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_seven_segment_digits_unit
// Formats a signed Q16.16 value in radix 2..16 as four seven-segment patterns.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: value[31:0], radix[36:32], fraction_digits[39:37]
// m_axis    out        tdata: segments_0..segments_3 (8 bits each, low first)
//                      tuser: overflow
//
// A transaction passes through LIMIT (limit = radix**DIGITS, radix**(DIGITS-1)
// when negative), SCALE (up to F scalings by the radix for the clamped fraction
// request F), CONV (bit-serial radix conversion, one bit of the scaled number
// per cycle) and FMT. An overflow skips CONV.
// Reset is synchronous and clears the sequencer and the output valid.
// A result held by a stalled m_axis blocks only the formatting step; the next
// input is taken as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
module number_to_seven_segment_digits_unit
  import n7seg_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // value, radix, fraction_digits
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // segments_0, _1, _2, _3
  output logic             m_axis_tuser    // overflow
);

  localparam int NUM_W   = 4 * DIGITS;
  localparam int LIMIT_W = 4 * DIGITS + 1;
  localparam int LCNT_W  = $clog2(DIGITS + 1);
  localparam int BCNT_W  = $clog2(NUM_W);

  state_t state, state_next;

  logic [VALUE_W-1:0] raw;
  logic               neg;
  logic [RADIX_W-1:0] base;
  logic [FRAC_W-1:0]  reqf;
  logic [LIMIT_W-1:0] limit;
  logic [LCNT_W-1:0]  lcnt;
  logic [PROD_W-1:0]  prod;
  logic [FRAC_W-1:0]  k;
  logic [FRAC_W-1:0]  f;
  logic               found;
  logic               err;
  logic [NUM_W-1:0]   num;
  logic [BCNT_W-1:0]  bcnt;
  logic [3:0]         dig      [DIGITS];
  logic [3:0]         dig_next [DIGITS];

  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_radix;
  logic [FRAC_W-1:0]  in_frac;
  logic [RADIX_W-1:0] in_base;
  logic [FRAC_W-1:0]  in_reqf;
  logic               accept;
  logic               out_load;
  logic [VALUE_W-1:0] mag;
  logic [PROD_W-1:0]  prod_rnd;
  logic [RND_W-1:0]   rnd;
  logic               fits;
  logic               more;
  logic [DIGITS:0]    carry;
  logic [DIGITS-1:0]  dig_nz;
  logic               nz;
  logic [CNT_W-1:0]   ndig;
  logic [CNT_W-1:0]   fp1;
  logic [CNT_W-1:0]   count;
  logic [SEG_W-1:0]   seg [4];

  assign in_value = s_axis_tdata[31:0];
  assign in_radix = s_axis_tdata[36:32];
  assign in_frac  = s_axis_tdata[39:37];
  assign in_base  = (in_radix < RADIX_MIN) ? RADIX_MIN :
                    (in_radix > RADIX_MAX) ? RADIX_MAX : in_radix;
  assign in_reqf  = (in_frac > FRAC_MAX) ? FRAC_MAX : in_frac;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == ST_FMT) && (!m_axis_tvalid || m_axis_tready);

  assign mag      = neg ? (~raw + 32'd1) : raw;
  assign prod_rnd = prod + PROD_W'(ROUND_HALF);
  assign rnd      = prod_rnd[PROD_W-1:FRAC_BITS];
  assign fits     = CMP_W'(rnd) < CMP_W'(limit);
  assign more     = fits && (k < reqf);

  // one bit of num into the digit row: digits = digits * 2 + bit, in radix base
  assign carry[0] = num[NUM_W-1];
  for (genvar i = 0; i < DIGITS; i++) begin : g_chain
    logic [4:0] t;
    assign t            = {dig[i], 1'b0} + 5'(carry[i]);
    assign carry[i + 1] = (t >= base);
    assign dig_next[i]  = (t >= base) ? 4'(t - base) : t[3:0];
    assign dig_nz[i]    = |dig[i];
  end

  always_comb begin
    ndig = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (dig_nz[i]) ndig = CNT_W'(i + 1);
    end
  end

  assign nz    = |dig_nz;
  assign fp1   = CNT_W'(f) + CNT_W'(1);
  assign count = !nz ? CNT_W'(1) : ((ndig > fp1) ? ndig : fp1);

  for (genvar j = 0; j < 4; j++) begin : g_seg
    localparam int I = 3 - j;
    if (I < DIGITS) begin : g_on
      assign seg[j] = err ? ((j == 6 - DIGITS) ? SEG_BLANK : SEG_MINUS) :
                      (CNT_W'(I) < count) ?
                        {(nz && (f != '0) && (f == FRAC_W'(I))), glyph(dig[I])} :
                      (neg && (CNT_W'(I) == count)) ? SEG_MINUS : SEG_BLANK;
    end else begin : g_off
      assign seg[j] = SEG_BLANK;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LIMIT;
      end
      ST_LIMIT: begin
        if (lcnt == '0) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (!more) state_next = (found || fits) ? ST_CONV : ST_FMT;
      end
      ST_CONV: begin
        if (bcnt == '0) state_next = ST_FMT;
      end
      ST_FMT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          raw   <= in_value;
          neg   <= in_value[VALUE_W-1];
          base  <= in_base;
          reqf  <= in_reqf;
          limit <= LIMIT_W'(1);
          lcnt  <= in_value[VALUE_W-1] ? LCNT_W'(DIGITS - 1) : LCNT_W'(DIGITS);
          k     <= '0;
          f     <= '0;
          found <= 1'b0;
          err   <= 1'b0;
          num   <= '0;
          bcnt  <= BCNT_W'(NUM_W - 1);
          dig   <= '{default: '0};
        end
      end
      ST_LIMIT: begin
        prod <= PROD_W'(mag);
        if (lcnt != '0) begin
          limit <= LIMIT_W'(limit * LIMIT_W'(base));
          lcnt  <= lcnt - LCNT_W'(1);
        end
      end
      ST_SCALE: begin
        if (fits) begin
          num   <= rnd[NUM_W-1:0];
          f     <= k;
          found <= 1'b1;
        end
        if (more) begin
          prod <= PROD_W'(prod * PROD_W'(base));
          k    <= k + FRAC_W'(1);
        end else begin
          err <= !(found || fits);
        end
      end
      ST_CONV: begin
        dig  <= dig_next;
        num  <= {num[NUM_W-2:0], 1'b0};
        bcnt <= bcnt - BCNT_W'(1);
      end
      ST_FMT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {seg[3], seg[2], seg[1], seg[0]};
      m_axis_tuser <= err;
    end
  end

  a_conv_no_err: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (!err && found))
    else $error("conversion running on an overflowed value");

  a_digit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> ({1'b0, dig[DIGITS-1]} < base))
    else $error("top digit outside radix");

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FMT && !err) |-> (f <= reqf))
    else $error("chosen fraction count above request");

  a_overflow_no_point: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (!m_axis_tdata[7] && !m_axis_tdata[15] && !m_axis_tdata[23] && !m_axis_tdata[31]))
    else $error("decimal point shown with overflow");

endmodule
